[src/tlst_pkg.sv]
// ----------------------------------------------------------------------------
// tlst_pkg
// Shared types and constants for the two-line LCD scroll terminal.
// ----------------------------------------------------------------------------
package tlst_pkg;

	localparam logic [7:0] CR_CODE = 8'd13;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_GOTO  = 2'd2
	} cmd_kind_t;

	// classified input word handed from front to back
	typedef struct packed {
		logic       is_cr;
		logic [7:0] code;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HOME,
		ST_REPLAY,
		ST_TAIL
	} seq_state_t;

endpackage

[src/tlst_front.sv]
// ----------------------------------------------------------------------------
// tlst_front
// Input stage: accepts received bytes and tags carriage returns.
// ----------------------------------------------------------------------------
module tlst_front import tlst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       char_valid,
	output logic       char_ready,
	output op_t        op,
	output logic       op_valid,
	input  logic       op_ready
);

	logic v_s1;
	op_t  op_s1;

	assign char_ready = !v_s1 || op_ready;
	assign op_valid   = v_s1;
	assign op         = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_ready) begin
			v_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			op_s1.is_cr <= (char_code == CR_CODE);
			op_s1.code  <= char_code;
		end
	end

endmodule

[src/tlst_queue.sv]
// ----------------------------------------------------------------------------
// tlst_queue
// Two-entry word queue between the input stage and the command sequencer.
// ----------------------------------------------------------------------------
module tlst_queue import tlst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  op_t  push_op,
	input  logic push_valid,
	output logic push_ready,
	output op_t  pop_op,
	output logic pop_valid,
	input  logic pop_ready
);

	localparam int unsigned DEPTH = 2;

	op_t        entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'(DEPTH));
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[src/tlst_back.sv]
// ----------------------------------------------------------------------------
// tlst_back
// Command sequencer: tracks the cursor, keeps the lower line, replays it on
// scroll and emits LCD commands through an output register.
// ----------------------------------------------------------------------------
module tlst_back import tlst_pkg::*; #(
	parameter int unsigned COLUMNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        op,
	input  logic       op_valid,
	output logic       op_ready,
	output logic [1:0] command_kind,
	output logic [7:0] char_value,
	output logic       cursor_row,
	output logic [3:0] cursor_column,
	output logic       last_of_run,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	localparam int unsigned CW = $clog2(COLUMNS + 1);
	localparam int unsigned IW = $clog2(COLUMNS);

	seq_state_t state_q, state_d;
	logic          row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [CW-1:0] filled_q, filled_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] col_inc;
	logic [IW-1:0] rd_addr;
	logic [7:0]    rd_q;
	logic [7:0]    line_mem [COLUMNS];
	logic          wr_en;
	logic          slot_free;

	logic          emit;
	cmd_kind_t     e_kind;
	logic [7:0]    e_char;
	logic          e_row;
	logic [CW-1:0] e_col;
	logic          e_last;

	logic       cmd_valid_q;
	cmd_kind_t  kind_q;
	logic [7:0] char_q;
	logic       row_out_q;
	logic [3:0] col_out_q;
	logic       last_q;

	assign slot_free = !cmd_valid_q || cmd_ready;
	assign col_inc   = col_q + CW'(1);

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		filled_d = filled_q;
		idx_d    = idx_q;
		op_ready = 1'b0;
		wr_en    = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_GOTO;
		e_char   = 8'd0;
		e_row    = 1'b0;
		e_col    = '0;
		e_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (op_valid && slot_free) begin
					op_ready = 1'b1;
					emit     = 1'b1;
					if (op.is_cr) begin
						col_d = '0;
						if (!row_q) begin
							row_d  = 1'b1;
							e_kind = KIND_GOTO;
							e_row  = 1'b1;
							e_last = 1'b1;
						end else begin
							filled_d = col_q;
							e_kind   = KIND_CLEAR;
							state_d  = ST_HOME;
						end
					end else begin
						wr_en  = row_q;
						e_kind = KIND_DATA;
						e_char = op.code;
						if (col_inc == CW'(COLUMNS)) begin
							col_d = '0;
							if (!row_q) begin
								row_d   = 1'b1;
								state_d = ST_TAIL;
							end else begin
								filled_d = CW'(COLUMNS);
								state_d  = ST_CLEAR;
							end
						end else begin
							col_d   = col_inc;
							state_d = ST_TAIL;
						end
					end
				end
			end
			ST_CLEAR: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_CLEAR;
					state_d = ST_HOME;
				end
			end
			ST_HOME: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_GOTO;
					idx_d   = '0;
					state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				if (slot_free) begin
					emit = 1'b1;
					// stop at the end of the saved line or at a zero byte
					if (idx_q == filled_q || rd_q == 8'd0) begin
						e_kind  = KIND_GOTO;
						e_row   = row_q;
						e_col   = col_q;
						e_last  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						e_kind = KIND_DATA;
						e_char = rd_q;
						idx_d  = idx_q + CW'(1);
					end
				end
			end
			ST_TAIL: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_GOTO;
					e_row   = row_q;
					e_col   = col_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// prefetch the entry the replay will need next
	assign rd_addr = (idx_d < CW'(COLUMNS)) ? idx_d[IW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= 1'b0;
			col_q       <= '0;
			filled_q    <= '0;
			idx_q       <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			col_q    <= col_d;
			filled_q <= filled_d;
			idx_q    <= idx_d;
			if (emit) begin
				cmd_valid_q <= 1'b1;
			end else if (cmd_ready) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[col_q[IW-1:0]] <= op.code;
		end
		rd_q <= line_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= e_kind;
			char_q    <= e_char;
			row_out_q <= e_row;
			col_out_q <= 4'(e_col);
			last_q    <= e_last;
		end
	end

	assign command_kind  = kind_q;
	assign char_value    = char_q;
	assign cursor_row    = row_out_q;
	assign cursor_column = col_out_q;
	assign last_of_run   = last_q;
	assign cmd_valid     = cmd_valid_q;

endmodule

[src/two_line_lcd_scroll_terminal_unit.sv]
// A byte passes the input register, the queue and the output register before its first LCD command leaves.
// Throughput: the sequencer issues one command per cycle unless cmd_ready holds it off;
// a byte makes 1-2 commands normally, up to COLUMNS + 4 on a scroll.
// A two-word queue lets bytes keep arriving while a scroll is replayed, until it is full.
// Reset: cursor home on the upper row, queue and output emptied; the saved
// lower line is not cleared.
// ----------------------------------------------------------------------------
// two_line_lcd_scroll_terminal_unit
// Drives a two-row character LCD as a scrolling terminal, one byte at a time.
// ----------------------------------------------------------------------------
module two_line_lcd_scroll_terminal_unit import tlst_pkg::*; #(
	parameter int unsigned COLUMNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       char_valid,
	output logic       char_ready,
	output logic [1:0] command_kind,
	output logic [7:0] char_value,
	output logic       cursor_row,
	output logic [3:0] cursor_column,
	output logic       last_of_run,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	op_t  f_op;
	logic f_valid;
	logic f_ready;
	op_t  q_op;
	logic q_valid;
	logic q_ready;

	tlst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_code),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.op         (f_op),
		.op_valid   (f_valid),
		.op_ready   (f_ready)
	);

	tlst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (f_op),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_op     (q_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	tlst_back #(
		.COLUMNS (COLUMNS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (q_op),
		.op_valid      (q_valid),
		.op_ready      (q_ready),
		.command_kind  (command_kind),
		.char_value    (char_value),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.last_of_run   (last_of_run),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready)
	);

`ifndef SYNTHESIS
	a_last_is_goto: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && last_of_run |-> command_kind == KIND_GOTO)
		else $error("run ends on a command other than set position");

	a_pos_only_goto: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && command_kind != KIND_GOTO |-> !cursor_row && cursor_column == 4'd0)
		else $error("cursor fields set on a non-position command");

	a_char_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && command_kind != KIND_DATA |-> char_value == 8'd0)
		else $error("character set on a non-data command");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> q_valid)
		else $error("sequencer took a word from an empty queue");
`endif

endmodule
